// ===== src/sts_pkg.sv =====
// Shared constants, command codes and the stage word type for the sorted table search.
`timescale 1ns / 1ps
`default_nettype none
package sts_pkg;

   localparam int STS_DEPTH = 1024;
   localparam int KEY_W     = 64;
   localparam int CMD_W     = 2;
   localparam int EIDX_W    = 10;
   localparam int LEN_W     = 11;
   // Wide enough to hold any index or length up to the largest supported depth (65536).
   localparam int POS_W     = 17;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EXACT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOWER = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UPPER = 2'd3;

   // One word as it travels down the probe pipeline.
   typedef struct packed {
      logic                    valid;
      logic [CMD_W-1:0]        cmd;
      logic [EIDX_W-1:0]       entry_index;
      logic signed [KEY_W-1:0] value;
      logic [POS_W-1:0]        lo;
      logic [POS_W-1:0]        hi;
      logic [POS_W-1:0]        len;
      logic                    done;
      logic                    hit;
   } stage_type;

endpackage
`default_nettype wire

// ===== src/sts_probe.sv =====
// One probe step of the search: a private copy of the table, a registered read and an update.
`timescale 1ns / 1ps
`default_nettype none
module sts_probe import sts_pkg::*; #(
   parameter int DEPTH = STS_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   input  wire stage_type stage_in,
   output stage_type      stage_out
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [KEY_W-1:0] mem [DEPTH];

   stage_type        hold_ff;
   logic [POS_W-1:0] mid_ff;
   logic             act_ff;
   logic [KEY_W-1:0] rd_ff;
   stage_type        out_ff;
   stage_type        out_in;

   logic [POS_W:0]   sum;
   logic [POS_W-1:0] mid;
   logic             active;
   logic             is_write;
   logic [POS_W-1:0] widx;

   always_comb begin
      sum      = {1'b0, stage_in.lo} + {1'b0, stage_in.hi};
      // Exact search probes (l + r) / 2 over the inclusive range, the bounds (lo + hi) / 2.
      if (stage_in.cmd == CMD_EXACT) begin
         mid = POS_W'((sum - (POS_W+1)'(1)) >> 1);
      end else begin
         mid = POS_W'(sum >> 1);
      end
      is_write = stage_in.valid && (stage_in.cmd == CMD_WRITE);
      active   = stage_in.valid && !is_write && !stage_in.done && (stage_in.lo < stage_in.hi);
      widx     = POS_W'(stage_in.entry_index);
   end

   // Writes pass each copy in order with the searches, so every search sees the table
   // exactly as it stood when that search was accepted.
   always_ff @(posedge clock) begin
      if (advance) begin
         if (is_write && (32'(widx) < DEPTH)) begin
            mem[widx[AW-1:0]] <= stage_in.value;
         end else if (active) begin
            rd_ff <= mem[mid[AW-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff.valid <= 1'b0;
         out_ff.valid  <= 1'b0;
      end else if (advance) begin
         hold_ff <= stage_in;
         out_ff  <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mid_ff <= mid;
         act_ff <= active;
      end
   end

   always_comb begin
      out_in = hold_ff;
      if (act_ff) begin
         unique case (hold_ff.cmd)
            CMD_EXACT: begin
               if (rd_ff == hold_ff.value) begin
                  out_in.done = 1'b1;
                  out_in.hit  = 1'b1;
                  out_in.lo   = mid_ff;
               end else if ($signed(rd_ff) < hold_ff.value) begin
                  out_in.lo = mid_ff + POS_W'(1);
               end else begin
                  out_in.hi = mid_ff;
               end
            end
            CMD_LOWER: begin
               if ($signed(rd_ff) >= hold_ff.value) begin
                  out_in.hi = mid_ff;
               end else begin
                  out_in.lo = mid_ff + POS_W'(1);
               end
            end
            CMD_UPPER: begin
               if ($signed(rd_ff) > hold_ff.value) begin
                  out_in.hi = mid_ff;
               end else begin
                  out_in.lo = mid_ff + POS_W'(1);
               end
            end
            default: begin
               out_in = hold_ff;
            end
         endcase
      end
   end

   assign stage_out = out_ff;

endmodule
`default_nettype wire

// ===== src/sorted_table_search.sv =====
// Top level of the sorted table search: length register, probe pipeline and result register.
//
//   channel  direction  handshake          word
//   req_     in         req_valid/stall    command, entry_index, value
//   rsp_     out        rsp_valid/stall    position, found
//   csr_     in         csr_write_enable   table_length
//
// A word can enter every cycle while no result word is stalled. Each of the $clog2(DEPTH+1) probe
// steps has a registered table read followed by a registered compare, and the result register
// is loaded after the last step. Each step owns a copy of the table, which is what allows one
// word per cycle. Reset clears the length and all valid bits; the table is undefined until
// written. A stall on a waiting result word freezes the whole pipeline.
`timescale 1ns / 1ps
`default_nettype none
module sorted_table_search import sts_pkg::*; #(
   parameter int DEPTH = STS_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire logic [CMD_W-1:0]        req_command,
   input  wire logic [EIDX_W-1:0]       req_entry_index,
   input  wire logic signed [KEY_W-1:0] req_value,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      logic [LEN_W-1:0]        rsp_position,
   output      logic                    rsp_found,
   input  wire logic                    csr_write_enable,
   input  wire logic [LEN_W-1:0]        csr_write_data
);

   // Enough halvings to close any range of up to DEPTH entries.
   localparam int NSTEP = $clog2(DEPTH + 1);

   logic [LEN_W-1:0] length_ff;
   logic             advance;
   logic [POS_W-1:0] used_len;
   stage_type        chain [NSTEP+1];
   stage_type        last;

   logic             rsp_valid_ff;
   logic [LEN_W-1:0] rsp_position_ff;
   logic             rsp_found_ff;
   logic             rsp_valid_in;
   logic [LEN_W-1:0] rsp_position_in;
   logic             rsp_found_in;

   // The user must change the length register only while the block is idle; the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else if (csr_write_enable) begin
         length_ff <= csr_write_data;
      end
   end

   // The pipeline moves whenever the result register is empty or being taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // A length beyond the table depth is clamped to the depth.
   always_comb begin
      if (32'(length_ff) > DEPTH) begin
         used_len = POS_W'(DEPTH);
      end else begin
         used_len = POS_W'(length_ff);
      end
   end

   assign chain[0].valid       = req_valid;
   assign chain[0].cmd         = req_command;
   assign chain[0].entry_index = req_entry_index;
   assign chain[0].value       = req_value;
   assign chain[0].lo          = '0;
   assign chain[0].hi          = used_len;
   assign chain[0].len         = used_len;
   assign chain[0].done        = 1'b0;
   assign chain[0].hit         = 1'b0;

   for (genvar g = 0; g < NSTEP; g++) begin : g_step
      sts_probe #(.DEPTH(DEPTH)) u_probe (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (chain[g]),
         .stage_out (chain[g+1])
      );
   end

   assign last = chain[NSTEP];

   // Writes end in the last probe step; only searches make a result word.
   always_comb begin
      rsp_valid_in = last.valid && (last.cmd != CMD_WRITE);
      if (last.cmd == CMD_EXACT) begin
         rsp_found_in    = last.hit;
         rsp_position_in = last.hit ? LEN_W'(last.lo) : '0;
      end else begin
         rsp_found_in    = last.lo < last.len;
         rsp_position_in = LEN_W'(last.lo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_position_ff <= rsp_position_in;
         rsp_found_ff    <= rsp_found_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_found    = rsp_found_ff;

endmodule
`default_nettype wire

// ===== src/sts_checker.sv =====
// Port checker for the sorted table search, attached to the top level by a bind.
`timescale 1ns / 1ps
`default_nettype none
module sts_checker import sts_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [LEN_W-1:0] rsp_position,
   input wire logic             rsp_found
);

   // A stalled result word stays and holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position) && $stable(rsp_found))
      else $error("stalled result word changed");

   // A stalled result freezes the pipeline, so no new word may enter.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input accepted while result stalled");

   // With no result waiting the block always takes input.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

   // Reset empties the result register.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sorted_table_search sts_checker u_sts_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_position (rsp_position),
   .rsp_found    (rsp_found)
);
`default_nettype wire
